@@ hw/rtl/tlzw_pkg.sv @@
// tlzw_pkg: shared constants, codes and types of the tiff lzw encoder
// no dependencies; imported by tlzw_front, tlzw_engine, tlzw_packer and the top level
`default_nettype none

package tlzw_pkg;

   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 12;
   localparam int KEY_W       = CODE_W + BYTE_W;
   localparam int TABLE_DEPTH = 1 << KEY_W;
   localparam int REV_DEPTH   = 1 << CODE_W;
   localparam int BITS_W      = 4;
   localparam int ACC_W       = 19;
   localparam int CNT_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [CODE_W-1:0] CODE_CLEAR    = 12'd256;
   localparam logic [CODE_W-1:0] CODE_EOI      = 12'd257;
   localparam logic [CODE_W-1:0] CODE_FIRST    = 12'd258;
   localparam logic [CODE_W-1:0] CODE_RESET_AT = 12'd4094;
   localparam logic [BITS_W-1:0] BITS_MIN      = 4'd9;
   localparam logic [BITS_W-1:0] BITS_MAX      = 4'd12;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_present;
      logic              end_of_stream;
   } tlzw_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [BITS_W-1:0] width;
      logic              last;
      logic              eos;
   } tlzw_token_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ_TBL,
      ST_READ_REV,
      ST_CLEAR,
      ST_END_PREFIX,
      ST_END_EOI
   } tlzw_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/tiff_lzw_encoder.sv @@
// tiff_lzw_encoder: top level, byte stream in, msb-first tiff lzw code bytes out
// depends on tlzw_pkg, tlzw_front, tlzw_engine and tlzw_packer
//
//   group  dir  tdata            tuser         tlast
//   req_   in   [7:0] data_byte  byte_present  end_of_stream
//   rsp_   out  [7:0] out_byte   run_last      stream_last
//
// a dictionary hit or miss goes through the table read followed by the reverse index read;
// a miss also waits there until the packer takes its code
// the packer moves one byte or code per cycle unless stalled, so multi-byte items take longer
// reset is synchronous and needs no clearing pass: entries are checked against the reverse index
// a four-entry queue and the output hold stage let each side stall on its own
`default_nettype none

module tiff_lzw_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] run_last
   output logic       rsp_tlast    // stream_last
);
   import tlzw_pkg::*;

   logic           q_valid, q_ready;
   tlzw_item_type  q_item;
   logic           tok_valid, tok_ready;
   tlzw_token_type tok;

   tlzw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   tlzw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .tok_valid (tok_valid),
      .tok_ready (tok_ready),
      .tok       (tok)
   );

   tlzw_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (tok_valid),
      .tok_ready  (tok_ready),
      .tok        (tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ hw/rtl/tlzw_front.sv @@
// tlzw_front: input side, takes transactions, drops empty ones, queues the rest
// depends on tlzw_pkg
`default_nettype none

module tlzw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] byte_present
   input  logic                  req_tlast,   // end_of_stream
   output logic                  q_valid,
   input  logic                  q_ready,
   output tlzw_pkg::tlzw_item_type q_item
);
   import tlzw_pkg::*;

   tlzw_item_type     queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              accept;
   logic              keep;
   logic              pop;

   assign req_tready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;
   // items with neither byte nor end cause nothing
   assign keep       = accept && (req_tuser || req_tlast);
   assign q_valid    = count_ff != '0;
   assign q_item     = queue_ff[rd_ptr_ff];
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(keep) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         queue_ff[wr_ptr_ff] <= '{data_byte: req_tdata, byte_present: req_tuser,
                                  end_of_stream: req_tlast};
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tlzw_engine.sv @@
// tlzw_engine: dictionary sequencer, looks up (prefix, byte) and issues code tokens
// depends on tlzw_pkg; holds the code table and the reverse index memories
`default_nettype none

module tlzw_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  tlzw_pkg::tlzw_item_type q_item,
   output logic                    tok_valid,
   input  logic                    tok_ready,
   output tlzw_pkg::tlzw_token_type tok
);
   import tlzw_pkg::*;

   logic [CODE_W-1:0] table_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]  rev_mem [REV_DEPTH];

   tlzw_state_type    state_ff, state_in;
   tlzw_item_type     item_ff, item_in;
   logic [CODE_W-1:0] prefix_ff, prefix_in;
   logic [CODE_W-1:0] next_free_ff, next_free_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              open_ff, open_in;

   logic [CODE_W-1:0] tbl_rd_ff;
   logic              byp_ff;
   logic [CODE_W-1:0] byp_data_ff;
   logic [KEY_W-1:0]  rev_rd_ff;

   logic              tbl_we, tbl_re, rev_we, rev_re;
   logic [KEY_W-1:0]  tbl_wa, tbl_ra, rev_wd;
   logic [CODE_W-1:0] tbl_wd, rev_wa;

   logic [CODE_W-1:0] found;
   logic [KEY_W-1:0]  cur_key;
   logic [CODE_W-1:0] nf_plus;
   logic              hit, wrap, grow, done;

   // an entry counts only if its code was handed out since the last clear
   // and the reverse index still names this key
   assign found   = byp_ff ? byp_data_ff : tbl_rd_ff;
   assign cur_key = {prefix_ff, item_ff.data_byte};
   assign hit     = (found >= CODE_FIRST) && (found < next_free_ff) && (rev_rd_ff == cur_key);
   assign nf_plus = next_free_ff + 1'b1;
   assign wrap    = nf_plus == CODE_RESET_AT;
   assign grow    = (bits_ff < BITS_MAX) && ({1'b0, nf_plus} == ((CODE_W+1)'(1) << bits_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prefix_ff    <= '0;
         next_free_ff <= CODE_FIRST;
         bits_ff      <= BITS_MIN;
         open_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         next_free_ff <= next_free_in;
         bits_ff      <= bits_in;
         open_ff      <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prefix_in    = prefix_ff;
      next_free_in = next_free_ff;
      bits_in      = bits_ff;
      open_in      = open_ff;
      tok_valid    = 1'b0;
      tok          = '0;
      q_ready      = 1'b0;
      tbl_we       = 1'b0;
      tbl_wa       = cur_key;
      tbl_wd       = next_free_ff;
      tbl_re       = 1'b0;
      tbl_ra       = '0;
      rev_we       = 1'b0;
      rev_wa       = next_free_ff;
      rev_wd       = cur_key;
      rev_re       = 1'b0;
      done         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            done = 1'b1;
         end
         ST_START: begin
            tok_valid = 1'b1;
            tok = '{code: CODE_CLEAR, width: BITS_MIN, last: !item_ff.end_of_stream,
                    eos: 1'b0};
            if (tok_ready) begin
               next_free_in = CODE_FIRST;
               bits_in      = BITS_MIN;
               if (item_ff.byte_present) begin
                  prefix_in = {{(CODE_W-BYTE_W){1'b0}}, item_ff.data_byte};
                  open_in   = 1'b1;
               end
               if (!item_ff.end_of_stream) begin
                  state_in = ST_IDLE;
               end else if (item_ff.byte_present) begin
                  state_in = ST_END_PREFIX;
               end else begin
                  state_in = ST_END_EOI;
               end
            end
         end
         ST_READ_TBL: begin
            rev_re   = 1'b1;
            state_in = ST_READ_REV;
         end
         ST_READ_REV: begin
            if (hit) begin
               prefix_in = found;
               if (item_ff.end_of_stream) begin
                  state_in = ST_END_PREFIX;
               end else begin
                  done = 1'b1;
               end
            end else begin
               tok_valid = 1'b1;
               tok = '{code: prefix_ff, width: bits_ff,
                       last: !wrap && !item_ff.end_of_stream, eos: 1'b0};
               if (tok_ready) begin
                  tbl_we       = 1'b1;
                  rev_we       = 1'b1;
                  next_free_in = nf_plus;
                  if (grow && !wrap) begin
                     bits_in = bits_ff + 1'b1;
                  end
                  prefix_in = {{(CODE_W-BYTE_W){1'b0}}, item_ff.data_byte};
                  if (wrap) begin
                     state_in = ST_CLEAR;
                  end else if (item_ff.end_of_stream) begin
                     state_in = ST_END_PREFIX;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
         ST_CLEAR: begin
            tok_valid = 1'b1;
            tok = '{code: CODE_CLEAR, width: bits_ff, last: !item_ff.end_of_stream,
                    eos: 1'b0};
            if (tok_ready) begin
               next_free_in = CODE_FIRST;
               bits_in      = BITS_MIN;
               state_in     = item_ff.end_of_stream ? ST_END_PREFIX : ST_IDLE;
            end
         end
         ST_END_PREFIX: begin
            tok_valid = 1'b1;
            tok = '{code: prefix_ff, width: bits_ff, last: 1'b0, eos: 1'b0};
            if (tok_ready) begin
               state_in = ST_END_EOI;
            end
         end
         ST_END_EOI: begin
            tok_valid = 1'b1;
            tok = '{code: CODE_EOI, width: bits_ff, last: 1'b1, eos: 1'b1};
            if (tok_ready) begin
               open_in      = 1'b0;
               next_free_in = CODE_FIRST;
               bits_in      = BITS_MIN;
               prefix_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // take the next queued item in the cycle the current one finishes
      if (done) begin
         state_in = ST_IDLE;
         q_ready  = 1'b1;
         if (q_valid) begin
            item_in = q_item;
            tbl_re  = 1'b1;
            tbl_ra  = {prefix_in, q_item.data_byte};
            if (!open_in) begin
               state_in = ST_START;
            end else if (q_item.byte_present) begin
               state_in = ST_READ_TBL;
            end else begin
               state_in = ST_END_PREFIX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_wa] <= tbl_wd;
      end
      if (tbl_re) begin
         tbl_rd_ff   <= table_mem[tbl_ra];
         byp_ff      <= tbl_we && (tbl_wa == tbl_ra);
         byp_data_ff <= tbl_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[rev_wa] <= rev_wd;
      end
      if (rev_re) begin
         rev_rd_ff <= rev_mem[found];
      end
   end

   a_next_free_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff >= CODE_FIRST) && (next_free_ff <= CODE_RESET_AT))
      else $error("next free code out of range");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (bits_ff >= BITS_MIN) && (bits_ff <= BITS_MAX))
      else $error("code width out of range");

   a_eoi_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END_EOI) && tok_ready |=> !open_ff && (next_free_ff == CODE_FIRST))
      else $error("stream not closed after eoi");

endmodule

`default_nettype wire

@@ hw/rtl/tlzw_packer.sv @@
// tlzw_packer: msb-first bit packer with a one-byte hold stage and output register
// depends on tlzw_pkg; fed with code tokens by tlzw_engine
`default_nettype none

module tlzw_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tok_valid,
   output logic                     tok_ready,
   input  tlzw_pkg::tlzw_token_type tok,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,  // [7:0] out_byte
   output logic                     rsp_tuser,  // [0] run_last
   output logic                     rsp_tlast   // stream_last
);
   import tlzw_pkg::*;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              fin_ff, fin_in;
   logic              eos_ff, eos_in;
   logic              hold_v_ff, hold_v_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic              out_v_ff, out_v_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_rl_ff, out_rl_in;
   logic              out_sl_ff, out_sl_in;

   logic              out_free, push_ok, push;
   logic [BYTE_W-1:0] new_byte;

   assign out_free   = !out_v_ff || rsp_tready;
   assign push_ok    = !hold_v_ff || out_free;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_rl_ff;
   assign rsp_tlast  = out_sl_ff;

   always_comb begin
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      fin_in      = fin_ff;
      eos_in      = eos_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_byte_in = out_byte_ff;
      out_rl_in   = out_rl_ff;
      out_sl_in   = out_sl_ff;
      tok_ready   = 1'b0;
      push        = 1'b0;
      new_byte    = '0;

      priority if (cnt_ff >= CNT_W'(8)) begin
         if (push_ok) begin
            new_byte = BYTE_W'(acc_ff >> (cnt_ff - CNT_W'(8)));
            push     = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(8);
         end
      end else if (fin_ff && eos_ff && (cnt_ff != '0)) begin
         // final partial byte, zero padded in its low bits
         if (push_ok) begin
            new_byte = BYTE_W'(acc_ff << (CNT_W'(8) - cnt_ff));
            push     = 1'b1;
            cnt_in   = '0;
         end
      end else if (fin_ff) begin
         // item done: the held byte is its last one
         if (push_ok) begin
            if (hold_v_ff) begin
               out_v_in    = 1'b1;
               out_byte_in = hold_ff;
               out_rl_in   = 1'b1;
               out_sl_in   = eos_ff;
               hold_v_in   = 1'b0;
            end
            fin_in    = 1'b0;
            eos_in    = 1'b0;
            tok_ready = 1'b1;
         end
      end else begin
         tok_ready = 1'b1;
      end

      if (push) begin
         if (hold_v_ff) begin
            out_v_in    = 1'b1;
            out_byte_in = hold_ff;
            out_rl_in   = 1'b0;
            out_sl_in   = 1'b0;
         end
         hold_in   = new_byte;
         hold_v_in = 1'b1;
      end

      if (tok_valid && tok_ready) begin
         acc_in = ACC_W'(acc_ff << tok.width) | ACC_W'(tok.code);
         cnt_in = cnt_ff + CNT_W'(tok.width);
         fin_in = tok.last;
         eos_in = tok.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         fin_ff    <= 1'b0;
         eos_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         eos_ff    <= eos_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      hold_ff     <= hold_in;
      out_byte_ff <= out_byte_in;
      out_rl_ff   <= out_rl_in;
      out_sl_ff   <= out_sl_in;
   end

   a_stream_end_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_sl_ff |-> out_rl_ff)
      else $error("stream end byte not marked as run end");

   a_absorb_room: assert property (@(posedge clock) disable iff (reset)
      tok_valid && tok_ready |-> cnt_ff < CNT_W'(8))
      else $error("token taken with a whole byte still pending");

endmodule

`default_nettype wire

@@ tb/tiff_lzw_encoder_tb.sv @@
// tiff_lzw_encoder_tb: self-checking bench for the tiff lzw encoder, driving byte streams
// and checking every packed output byte against a built-in lzw model or a typed row's bytes
// depends on tlzw_pkg and tiff_lzw_encoder
`timescale 1ns / 100ps

module tiff_lzw_encoder_tb;
   import tlzw_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int ROWS = 25;
   localparam int LONG_EXTRA = 16;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_last;
   } coded_byte_type;

   typedef struct packed {
      tlzw_item_type item;
      logic          typed;
      logic [2:0]    n_typed;
      logic [31:0]   typed_bytes;   // first byte in the lowest bits
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [ROWS] = '{
      '{'{8'h5A, 1'b0, 1'b0}, 1'b1, 3'd0, 32'h0000_0000},
      '{'{8'hA5, 1'b0, 1'b1}, 1'b1, 3'd3, 32'h0040_4080},
      '{'{8'hFF, 1'b1, 1'b1}, 1'b1, 3'd4, 32'h20E0_3F80},
      '{'{8'h00, 1'b1, 1'b1}, 1'b1, 3'd4, 32'h2020_0080},
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'hC3, 1'b0, 1'b0}, 1'b1, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h7F, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h01, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'hFE, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h33, 1'b0, 1'b1}, 1'b0, 3'd0, 32'h0},
      '{'{8'hAB, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'hAB, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'hAB, 1'b1, 1'b1}, 1'b0, 3'd0, 32'h0},
      '{'{8'h10, 1'b1, 1'b0}, 1'b0, 3'd0, 32'h0},
      '{'{8'h20, 1'b1, 1'b1}, 1'b0, 3'd0, 32'h0},
      '{'{8'h55, 1'b0, 1'b0}, 1'b1, 3'd0, 32'h0},
      '{'{8'hA5, 1'b0, 1'b1}, 1'b1, 3'd3, 32'h0040_4080}
   };

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tuser = 1'b0;    // [0] byte_present
   logic       req_tlast = 1'b0;    // end_of_stream
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tuser;           // [0] run_last
   logic       rsp_tlast;           // stream_last

   // encoder model state
   logic [CODE_W-1:0] dict_code [int unsigned];
   logic [CODE_W-1:0] cur_prefix;
   logic [CODE_W-1:0] free_code;
   logic [BITS_W-1:0] code_width;
   logic [6:0]        pend_bits;
   logic [2:0]        pend_cnt;
   bit                stream_open;

   logic [7:0]     step_bytes [$];
   coded_byte_type expected_bytes [$];
   coded_byte_type want;

   int send_idle_pct = 21;
   int recv_idle_pct = 68;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int items_in = 0;
   int bytes_out = 0;
   int streams_closed = 0;
   int dict_resets = 0;
   int widest_code = 9;

   tiff_lzw_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void pack_code(input logic [CODE_W-1:0] code);
      logic [ACC_W-1:0] acc;
      int cnt;
      acc = (ACC_W'(pend_bits) << code_width) | ACC_W'(code);
      cnt = int'(pend_cnt) + int'(code_width);
      while (cnt >= 8) begin
         step_bytes.push_back(8'(acc >> (cnt - 8)));
         cnt -= 8;
      end
      pend_bits = 7'(acc & ((ACC_W'(1) << cnt) - 1));
      pend_cnt = 3'(cnt);
   endfunction

   function automatic void restart_dict();
      dict_code.delete();
      code_width = BITS_MIN;
      free_code = CODE_FIRST;
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      int unsigned key;
      key = {cur_prefix, b};
      if (dict_code.exists(key)) begin
         cur_prefix = dict_code[key];
         return;
      end
      pack_code(cur_prefix);
      dict_code[key] = free_code;
      free_code = free_code + 1'b1;
      if (free_code == CODE_RESET_AT) begin
         pack_code(CODE_CLEAR);
         restart_dict();
         dict_resets++;
      end else if (code_width < BITS_MAX && int'(free_code) == (1 << code_width)) begin
         code_width = code_width + 1'b1;
         if (int'(code_width) > widest_code) widest_code = int'(code_width);
      end
      cur_prefix = {4'd0, b};
   endfunction

   function automatic void lzw_encode_step(input tlzw_item_type it);
      step_bytes.delete();
      if (!it.byte_present && !it.end_of_stream) return;
      if (!stream_open) begin
         restart_dict();
         pend_bits = '0;
         pend_cnt = '0;
         pack_code(CODE_CLEAR);
         if (it.byte_present) begin
            cur_prefix = {4'd0, it.data_byte};
            stream_open = 1'b1;
         end
      end else if (it.byte_present) begin
         take_byte(it.data_byte);
      end
      if (it.end_of_stream) begin
         if (stream_open) pack_code(cur_prefix);
         pack_code(CODE_EOI);
         if (pend_cnt > 0) step_bytes.push_back(8'(int'(pend_bits) << (8 - int'(pend_cnt))));
         stream_open = 1'b0;
         restart_dict();
         pend_bits = '0;
         pend_cnt = '0;
         cur_prefix = '0;
         streams_closed++;
      end
   endfunction

   function automatic tlzw_item_type make_item(input logic [7:0] b, input logic p,
                                               input logic e);
      tlzw_item_type it;
      it.data_byte = b;
      it.byte_present = p;
      it.end_of_stream = e;
      return it;
   endfunction

   task automatic send_item(input tlzw_item_type it, input bit typed, input int n_typed,
                            input logic [31:0] typed_bytes);
      int k;
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it.data_byte;
      req_tuser <= it.byte_present;
      req_tlast <= it.end_of_stream;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_in++;
      lzw_encode_step(it);
      if (typed) begin
         step_bytes.delete();
         for (k = 0; k < n_typed; k++) step_bytes.push_back(typed_bytes[8*k +: 8]);
      end
      n = step_bytes.size();
      for (k = 0; k < n; k++) begin
         expected_bytes.push_back('{step_bytes[k], k == n - 1,
                                    (k == n - 1) && it.end_of_stream});
      end
   endtask

   task automatic send_random_streams(input int n_items);
      int sent;
      int len;
      int kind;
      int i;
      bit full;
      bit eos_on_byte;
      logic [7:0] base;
      logic [7:0] mask;
      logic [7:0] b;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1), 1'b0, 0, '0);
            sent++;
         end else begin
            len = (kind < 16) ? $urandom_range(40, 21) : $urandom_range(12, 1);
            full = ($urandom_range(2) == 0);
            eos_on_byte = $urandom_range(1);
            base = 8'($urandom_range(255));
            mask = full ? 8'hFF : 8'($urandom_range(3, 1));
            for (i = 0; i < len; i++) begin
               if ($urandom_range(99) < 8) begin
                  send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0), 1'b0, 0, '0);
               end
               b = base ^ (8'($urandom_range(255)) & mask);
               send_item(make_item(b, 1'b1, eos_on_byte && (i == len - 1)), 1'b0, 0, '0);
               sent++;
            end
            if (!eos_on_byte) begin
               send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1), 1'b0, 0, '0);
               sent++;
            end
         end
      end
   endtask

   // one long stream of random bytes: carries the code width past 9 bits under a long hold-off
   task automatic send_long_stream();
      int extra;
      extra = 0;
      hold_start = 1'b1;
      while (extra < LONG_EXTRA) begin
         send_item(make_item(8'($urandom_range(255)), 1'b1, 1'b0), 1'b0, 0, '0);
         if (code_width > BITS_MIN) extra++;
      end
      send_item(make_item(8'($urandom_range(255)), 1'b1, 1'b1), 1'b0, 0, '0);
   endtask

   initial begin
      int r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < ROWS; r++) begin
         send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
                   int'(DIRECTED_ROWS[r].n_typed), DIRECTED_ROWS[r].typed_bytes);
      end
      send_random_streams(40);
      send_idle_pct = 68;
      recv_idle_pct = 21;
      send_random_streams(40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_streams(30);
      send_long_stream();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d transactions in %0d streams, checked %0d output bytes",
               items_in, streams_closed, bytes_out);
      $display("code width reached %0d bits, %0d in-stream table resets, %0d mismatches",
               widest_code, dict_resets, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tiff_lzw_encoder_tb passed");
      end else begin
         $display("tiff_lzw_encoder_tb failed");
      end
      $finish;
   end

   // receiver side, with a long hold-off so the input side backs up
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_out++;
         if (expected_bytes.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected output byte %h run_last %b stream_last %b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
            end
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tuser !== want.run_last ||
                rsp_tlast !== want.stream_last) begin
               if (mismatch_count < 10) begin
                  $display("output %0d: expected %h %b %b, got %h %b %b", bytes_out,
                           want.out_byte, want.run_last, want.stream_last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, expected_bytes.size());
         $display("tiff_lzw_encoder_tb failed");
         $finish;
      end
   end

endmodule

@@ files.f @@
hw/rtl/tlzw_pkg.sv
hw/rtl/tlzw_front.sv
hw/rtl/tlzw_engine.sv
hw/rtl/tlzw_packer.sv
hw/rtl/tiff_lzw_encoder.sv
tb/tiff_lzw_encoder_tb.sv
